// File: src/hpc_pkg.sv
// shared types and constants of the hadamard precoder
package hpc_pkg;

    localparam int NSTRM      = 4;
    localparam int NANT       = 8;
    localparam int SAMPLE_W   = 16;
    localparam int PART_W     = 18;
    localparam int OUT_W      = 14;
    localparam int OUT_LSB    = 4;
    localparam int ANT_W      = $clog2(NANT);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int SCALE_W    = 18;
    localparam int PROD_W     = SAMPLE_W + SCALE_W;

    // 92681 / 16, four fraction bits
    localparam logic signed [SCALE_W-1:0] SCALE_Q4 = 18'sd92681;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PART_W-1:0]   t_part;
    typedef t_part                      t_part_arr [NSTRM];

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AP_MODE       = 3'd0,
        CFG_USER_INDEX    = 3'd1,
        CFG_STREAM0_OWNER = 3'd2,
        CFG_STREAM1_OWNER = 3'd3,
        CFG_STREAM2_OWNER = 3'd4,
        CFG_STREAM3_OWNER = 3'd5
    } t_cfg_idx;

    // 1 = subtract stream j on antenna row r
    localparam logic [NSTRM-1:0] HAD_NEG [NSTRM] = '{
        4'b0000,
        4'b1010,
        4'b1100,
        4'b0110
    };

    typedef struct packed {
        logic load;
        logic keep;
    } t_lane_ctl;

endpackage

// File: src/hpc_if.sv
// channel interfaces of the hadamard precoder
interface hpc_in_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] s0_re;
    logic signed [15:0] s0_im;
    logic signed [15:0] s1_re;
    logic signed [15:0] s1_im;
    logic signed [15:0] s2_re;
    logic signed [15:0] s2_im;
    logic signed [15:0] s3_re;
    logic signed [15:0] s3_im;

    modport source (
        output valid, s0_re, s0_im, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im,
        input  ready
    );
    modport sink (
        input  valid, s0_re, s0_im, s1_re, s1_im, s2_re, s2_im, s3_re, s3_im,
        output ready
    );
endinterface

interface hpc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  antenna;
    logic signed [13:0] out_re;
    logic signed [13:0] out_im;
    logic        last;

    modport source (output valid, antenna, out_re, out_im, last, input ready);
    modport sink   (input valid, antenna, out_re, out_im, last, output ready);
endinterface

interface hpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [7:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: src/hpc_scale_lane.sv
// one stream lane: scales a complex sample, or zeroes it when not kept, and holds it for the antenna pass
module hpc_scale_lane
    import hpc_pkg::*;
(
    input  logic      i_clk,
    input  t_lane_ctl i_ctl,
    input  t_sample   i_re,
    input  t_sample   i_im,
    output t_part     o_re,
    output t_part     o_im
);

    logic signed [PROD_W-1:0] w_prod_re;
    logic signed [PROD_W-1:0] w_prod_im;
    t_part                    n_re;
    t_part                    n_im;
    t_part                    r_re;
    t_part                    r_im;

    always_comb begin
        w_prod_re = PROD_W'(i_re) * PROD_W'(SCALE_Q4);
        w_prod_im = PROD_W'(i_im) * PROD_W'(SCALE_Q4);
        // keep bits 31..15 and sign extend to the accumulator width
        n_re = i_ctl.keep ? {w_prod_re[31], w_prod_re[31:15]} : '0;
        n_im = i_ctl.keep ? {w_prod_im[31], w_prod_im[31:15]} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_re <= n_re;
            r_im <= n_im;
        end
    end

    assign o_re = r_re;
    assign o_im = r_im;

endmodule

// File: src/hpc_combine.sv
// merging stage: walks the eight antennas and sums the signed lane values
module hpc_combine
    import hpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    output logic             o_free,
    input  t_part_arr        i_re,
    input  t_part_arr        i_im,
    hpc_out_if.source        o_out
);

    logic             r_s_vld;
    logic [ANT_W-1:0] r_ant;
    logic             r_o_vld;
    logic [ANT_W-1:0] r_o_ant;
    logic [OUT_W-1:0] r_o_re;
    logic [OUT_W-1:0] r_o_im;
    logic             r_o_last;

    logic             w_adv;
    logic             w_emit;
    logic             w_last;
    logic [NSTRM-1:0] w_neg;
    t_part            n_acc_re;
    t_part            n_acc_im;

    always_comb begin
        w_adv  = !r_o_vld || o_out.ready;
        w_emit = r_s_vld && w_adv;
        w_last = (r_ant == ANT_W'(NANT - 1));
        o_free = !r_s_vld || (w_emit && w_last);
        w_neg  = HAD_NEG[r_ant[1:0]];
        n_acc_re = '0;
        n_acc_im = '0;
        for (int j = 0; j < NSTRM; j++) begin
            if (w_neg[j]) begin
                n_acc_re = n_acc_re - i_re[j];
                n_acc_im = n_acc_im - i_im[j];
            end else begin
                n_acc_re = n_acc_re + i_re[j];
                n_acc_im = n_acc_im + i_im[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
            r_ant   <= '0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_load) begin
                r_s_vld <= 1'b1;
            end else if (w_emit && w_last) begin
                r_s_vld <= 1'b0;
            end
            if (w_emit) begin
                r_ant <= r_ant + 1'b1;
            end
            if (w_adv) begin
                r_o_vld <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_ant  <= r_ant;
            r_o_re   <= n_acc_re[OUT_LSB +: OUT_W];
            r_o_im   <= n_acc_im[OUT_LSB +: OUT_W];
            r_o_last <= w_last;
        end
    end

    assign o_out.valid   = r_o_vld;
    assign o_out.antenna = r_o_ant;
    assign o_out.out_re  = r_o_re;
    assign o_out.out_im  = r_o_im;
    assign o_out.last    = r_o_last;

endmodule

// File: src/hadamard_precoder_8x4.sv
// top level of the eight-antenna hadamard precoder for four complex streams
//
//  channel  dir  modport  payload
//  i_in     in   sink     s0_re..s3_im, 16-bit signed q1.15
//  o_out    out  source   antenna[2:0], out_re[13:0], out_im[13:0], last
//  i_cfg    in   sink     index[2:0], data[7:0], write request
//
// one input request yields eight results, one per cycle while the output is not
// stalled; that rate is set by the single result port
// the next item is taken in the cycle its predecessor's last antenna moves
// to the output register, so items stream with no gap
// synchronous active-low reset clears control state and sets the config registers to ap mode on, user 0, owners 0
// a stalled output holds its result; the antenna pass pauses with it
module hadamard_precoder_8x4
    import hpc_pkg::*;
#(
    parameter int UE_BITS = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hpc_in_if.sink    i_in,
    hpc_out_if.source o_out,
    hpc_cfg_if.sink   i_cfg
);

    // configuration registers
    logic               r_ap_mode;
    logic [UE_BITS-1:0] r_user;
    logic [UE_BITS-1:0] r_owner [NSTRM];

    logic               w_free;
    logic               w_load;
    logic [NSTRM-1:0]   w_keep;
    t_lane_ctl          w_ctl [NSTRM];
    t_sample            w_in_re [NSTRM];
    t_sample            w_in_im [NSTRM];
    t_part_arr          w_re;
    t_part_arr          w_im;

    // config writes are always taken; unknown indexes fall through
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ap_mode <= 1'b1;
            r_user    <= '0;
            for (int j = 0; j < NSTRM; j++) begin
                r_owner[j] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_AP_MODE:       r_ap_mode  <= i_cfg.data[0];
                CFG_USER_INDEX:    r_user     <= i_cfg.data[UE_BITS-1:0];
                CFG_STREAM0_OWNER: r_owner[0] <= i_cfg.data[UE_BITS-1:0];
                CFG_STREAM1_OWNER: r_owner[1] <= i_cfg.data[UE_BITS-1:0];
                CFG_STREAM2_OWNER: r_owner[2] <= i_cfg.data[UE_BITS-1:0];
                CFG_STREAM3_OWNER: r_owner[3] <= i_cfg.data[UE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input side: a new sample set loads the lanes once the merge stage frees up
    assign i_in.ready = w_free;
    assign w_load     = i_in.valid && w_free;

    assign w_in_re[0] = i_in.s0_re;
    assign w_in_im[0] = i_in.s0_im;
    assign w_in_re[1] = i_in.s1_re;
    assign w_in_im[1] = i_in.s1_im;
    assign w_in_re[2] = i_in.s2_re;
    assign w_in_im[2] = i_in.s2_im;
    assign w_in_re[3] = i_in.s3_re;
    assign w_in_im[3] = i_in.s3_im;

    // stream lanes: scale, and outside ap mode mask streams that belong to another user
    for (genvar g = 0; g < NSTRM; g++) begin : g_lane
        assign w_keep[g]     = r_ap_mode || (r_owner[g] == r_user);
        assign w_ctl[g].load = w_load;
        assign w_ctl[g].keep = w_keep[g];

        hpc_scale_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (w_ctl[g]),
            .i_re  (w_in_re[g]),
            .i_im  (w_in_im[g]),
            .o_re  (w_re[g]),
            .o_im  (w_im[g])
        );
    end

    // merge: one antenna per cycle into the output register while the output is not stalled
    hpc_combine u_combine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .o_free  (w_free),
        .i_re    (w_re),
        .i_im    (w_im),
        .o_out   (o_out)
    );

endmodule

// File: verif/tb_hadamard_precoder_8x4.sv
// self-checking testbench of the eight-antenna hadamard precoder
`timescale 1ns / 1ps

module tb_hadamard_precoder_8x4
    import hpc_pkg::*;
();

    localparam int UE_BITS     = 2;
    localparam int RESET_LEN   = 5;
    // quiet cycles after the last result before a register write or the end
    localparam int SETTLE_LEN  = 16;
    // long output hold-off, well past the block's own buffering
    localparam int HOLD_LEN    = 300;
    // watchdog on the whole run, given in nanoseconds
    localparam int RUN_LIMIT_NS = 5_000_000;

    // register indexes past the last register; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // gain 92681/16 with four fraction bits
    localparam logic signed [SCALE_W-1:0] GAIN_Q4 = 18'sd92681;

    // bit j set: stream j is subtracted on antenna row r (antenna mod 4)
    localparam logic [NSTRM-1:0] SUB_ROW [NSTRM] = '{
        4'b0000,
        4'b1010,
        4'b1100,
        4'b0110
    };

    typedef struct {
        t_sample re [NSTRM];
        t_sample im [NSTRM];
    } t_stream_set;

    typedef struct packed {
        logic [ANT_W-1:0]        antenna;
        logic signed [OUT_W-1:0] re;
        logic signed [OUT_W-1:0] im;
        logic                    last;
    } t_antenna_out;

    logic i_clk;
    logic i_rst_n;

    hpc_in_if  in_ch ();
    hpc_out_if out_ch ();
    hpc_cfg_if cfg_ch ();

    hadamard_precoder_8x4 #(
        .UE_BITS (UE_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // mirror of the configuration registers, updated on each accepted write
    logic               ap_mode_m;
    logic [UE_BITS-1:0] user_m;
    logic [UE_BITS-1:0] owner_m [NSTRM];

    // antenna results still owed by the block, oldest first
    t_antenna_out pending_antennas [$];

    int mismatch_count = 0;

    // idling controls: sender gaps are read by the stimulus thread only,
    // the receiver flags are driven with nonblocking writes at clock edges
    bit   tx_gaps_on   = 1'b1;
    logic rx_stalls_on = 1'b1;
    logic hold_req     = 1'b0;
    int   stall_left   = 0;

    // ---------------------------------------------------------------
    // clock and run limit
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // q1.15 times the gain, floored to 5 fraction bits at 18 bits, then the
    // lowest bit dropped and the 17-bit value sign-extended back to 18
    function automatic t_part scale_sample(input t_sample x);
        logic signed [PROD_W-1:0] prod;
        prod = x * GAIN_Q4;
        return {prod[31], prod[31:15]};
    endfunction

    // work out all eight antenna results of one request and queue them
    function automatic void predict_antennas(input t_stream_set s);
        t_part        part_re [NSTRM];
        t_part        part_im [NSTRM];
        logic         used    [NSTRM];
        logic [PART_W-1:0] acc_re;
        logic [PART_W-1:0] acc_im;
        t_antenna_out res;
        for (int j = 0; j < NSTRM; j++) begin
            part_re[j] = scale_sample(s.re[j]);
            part_im[j] = scale_sample(s.im[j]);
            // outside ap mode only streams owned by this user count
            used[j] = ap_mode_m || (owner_m[j] == user_m);
        end
        for (int a = 0; a < NANT; a++) begin
            acc_re = '0;
            acc_im = '0;
            for (int j = 0; j < NSTRM; j++) begin
                if (used[j]) begin
                    if (SUB_ROW[a % NSTRM][j]) begin
                        acc_re = acc_re - part_re[j];
                        acc_im = acc_im - part_im[j];
                    end else begin
                        acc_re = acc_re + part_re[j];
                        acc_im = acc_im + part_im[j];
                    end
                end
            end
            res.antenna = a[ANT_W-1:0];
            // drop the four fraction bits, keep a wrapping 14-bit integer
            res.re      = acc_re[OUT_LSB +: OUT_W];
            res.im      = acc_im[OUT_LSB +: OUT_W];
            res.last    = (a == NANT - 1);
            pending_antennas.push_back(res);
        end
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // idle stretch of random length: mostly short, now and then much longer
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random sample, biased toward the corners of the q1.15 range
    function automatic t_sample random_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_stream_set random_streams();
        t_stream_set s;
        for (int j = 0; j < NSTRM; j++) begin
            s.re[j] = random_sample();
            s.im[j] = random_sample();
        end
        return s;
    endfunction

    function automatic t_stream_set uniform_streams(input t_sample re, input t_sample im);
        t_stream_set s;
        for (int j = 0; j < NSTRM; j++) begin
            s.re[j] = re;
            s.im[j] = im;
        end
        return s;
    endfunction

    // offer one sample set and hold it until the block takes it;
    // valid is only lowered when a gap precedes the request
    task automatic send_streams(input t_stream_set s);
        int gap;
        gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.s0_re <= s.re[0];
        in_ch.s0_im <= s.im[0];
        in_ch.s1_re <= s.re[1];
        in_ch.s1_im <= s.im[1];
        in_ch.s2_re <= s.re[2];
        in_ch.s2_im <= s.im[2];
        in_ch.s3_re <= s.re[3];
        in_ch.s3_im <= s.im[3];
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_antennas(s);
    endtask

    // stop offering and wait until every owed result came back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_antennas.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LEN) @(posedge i_clk);
    endtask

    // one register write request; the mirror follows on acceptance
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_AP_MODE:       ap_mode_m  = value[0];
            CFG_USER_INDEX:    user_m     = value[UE_BITS-1:0];
            CFG_STREAM0_OWNER: owner_m[0] = value[UE_BITS-1:0];
            CFG_STREAM1_OWNER: owner_m[1] = value[UE_BITS-1:0];
            CFG_STREAM2_OWNER: owner_m[2] = value[UE_BITS-1:0];
            CFG_STREAM3_OWNER: owner_m[3] = value[UE_BITS-1:0];
            default: ;  // spare index, the block drops it
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] ap, input logic [CFG_DATA_W-1:0] ue,
                             input logic [CFG_DATA_W-1:0] o0, input logic [CFG_DATA_W-1:0] o1,
                             input logic [CFG_DATA_W-1:0] o2, input logic [CFG_DATA_W-1:0] o3);
        write_register(CFG_AP_MODE, ap);
        write_register(CFG_USER_INDEX, ue);
        write_register(CFG_STREAM0_OWNER, o0);
        write_register(CFG_STREAM1_OWNER, o1);
        write_register(CFG_STREAM2_OWNER, o2);
        write_register(CFG_STREAM3_OWNER, o3);
    endtask

    task automatic set_idling(input bit tx_on, input bit rx_on);
        tx_gaps_on = tx_on;
        rx_stalls_on <= rx_on;
    endtask

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_antenna_out want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_antennas.size() == 0) begin
                $error("antenna result with no request pending: antenna %0d", out_ch.antenna);
                mismatch_count++;
            end else begin
                want = pending_antennas.pop_front();
                if (out_ch.antenna !== want.antenna) begin
                    $error("antenna: expected %0d, got %0d", want.antenna, out_ch.antenna);
                    mismatch_count++;
                end
                if (out_ch.out_re !== want.re) begin
                    $error("out_re (antenna %0d): expected %0d, got %0d",
                           want.antenna, want.re, out_ch.out_re);
                    mismatch_count++;
                end
                if (out_ch.out_im !== want.im) begin
                    $error("out_im (antenna %0d): expected %0d, got %0d",
                           want.antenna, want.im, out_ch.out_im);
                    mismatch_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last (antenna %0d): expected %0d, got %0d",
                           want.antenna, want.last, out_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // output back-pressure, counted in cycles
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        // a hold-off request overrides random stalls for a long stretch
        if (hold_req)
            stall_left = HOLD_LEN;
        else if (stall_left > 0)
            stall_left--;
        else if (rx_stalls_on && $urandom_range(0, 3) == 0)
            stall_left = idle_len();
        out_ch.ready <= (stall_left == 0);
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset values: ap mode on, so every stream reaches every antenna;
    // corners of the sample range, floor of small negatives, overflow
    // wrap, and each stream alone to expose its sign on all four rows
    task automatic test_reset_config();
        t_stream_set s;
        send_streams(uniform_streams(16'sh0000, 16'sh0000));
        send_streams(uniform_streams(16'sh7FFF, 16'sh7FFF));
        send_streams(uniform_streams(16'sh8000, 16'sh8000));
        send_streams(uniform_streams(16'shFFFF, 16'sh0001));
        send_streams(uniform_streams(16'sh0001, 16'shFFFF));
        send_streams(uniform_streams(16'sh7FFF, 16'sh8000));
        for (int j = 0; j < NSTRM; j++) begin
            s = uniform_streams(16'sh0000, 16'sh0000);
            s.re[j] = 16'sh4000;
            s.im[j] = -16'sh2001;
            send_streams(s);
        end
        // alternating full-scale signs across streams
        s.re = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
        s.im = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
        send_streams(s);
        drain();
    endtask

    // each register written at least once, extremes included, with data
    // wider than the field and writes to the spare indexes
    task automatic test_register_writes();
        // non-ap, user 0, each stream owned by a different user: stream 0 only
        write_all(8'h00, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03);
        send_streams(uniform_streams(16'sh7FFF, 16'sh8000));
        send_streams(random_streams());
        drain();

        // 0xFE keeps only the low bits: user 2, so stream 2 only
        write_register(CFG_USER_INDEX, 8'hFE);
        send_streams(uniform_streams(16'sh4000, 16'shC000));
        send_streams(random_streams());
        drain();

        // user 3 owning streams 0, 1 and 3; stream 2 dropped
        write_all(8'hF0, 8'hFF, 8'h07, 8'h0B, 8'h00, 8'hFF);
        send_streams(uniform_streams(16'sh7FFF, 16'sh7FFF));
        send_streams(random_streams());
        drain();

        // user owns nothing: every antenna is zero
        write_register(CFG_USER_INDEX, 8'h01);
        send_streams(uniform_streams(16'sh8000, 16'sh7FFF));
        drain();

        // spare indexes must leave the configuration untouched
        write_register(CFG_SPARE_LO, 8'hFF);
        write_register(CFG_SPARE_HI, 8'hFF);
        send_streams(random_streams());
        drain();

        // ap mode back on via an odd wide value: owners ignored again
        write_register(CFG_AP_MODE, 8'hFF);
        send_streams(random_streams());
        send_streams(uniform_streams(16'shFFFF, 16'shFFFF));
        drain();
    endtask

    // random register values, random samples, both sides idling
    task automatic test_random_configs();
        for (int phase = 0; phase < 8; phase++) begin
            // every third phase forces non-ap mode so owner matching gets exercised
            write_all((phase % 3 == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
            repeat (20) send_streams(random_streams());
            drain();
        end
    endtask

    // receiver holds off for a long stretch while requests keep coming,
    // so the block fills and must stall its input
    task automatic test_output_hold_off();
        set_idling(1'b0, 1'b0);
        write_register(CFG_AP_MODE, 8'h01);
        hold_req <= 1'b1;
        @(posedge i_clk);
        hold_req <= 1'b0;
        repeat (30) send_streams(random_streams());
        drain();
    endtask

    // no idling on either side, so results stream at the full rate
    task automatic test_full_rate();
        set_idling(1'b0, 1'b0);
        write_all(8'h00, 8'h02, 8'h02, 8'h01, 8'h02, 8'h02);
        repeat (40) send_streams(random_streams());
        drain();
        set_idling(1'b1, 1'b1);
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.s0_re  = '0;
        in_ch.s0_im  = '0;
        in_ch.s1_re  = '0;
        in_ch.s1_im  = '0;
        in_ch.s2_re  = '0;
        in_ch.s2_im  = '0;
        in_ch.s3_re  = '0;
        in_ch.s3_im  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        out_ch.ready = 1'b0;

        // register values after reset
        ap_mode_m = 1'b1;
        user_m    = '0;
        for (int j = 0; j < NSTRM; j++)
            owner_m[j] = '0;

        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_config();
        test_register_writes();
        test_random_configs();
        test_output_hold_off();
        test_full_rate();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
